// ===== hw/rtl/slcpd_pkg.sv =====
// shared types, constants and crc step for the sync/length/crc packet deframer
package slcpd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CRC_W     = 16;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned PLEN_W    = 5;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h55;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hAA;
  localparam logic [BYTE_W-1:0] MIN_LEN     = 8'd4;
  localparam logic [CRC_W-1:0]  CRC_POLY_RST = 16'h1021;

  // commands from the controller to the datapath
  typedef struct packed {
    logic len_load;   // take the current beat as packet length
    logic byte_take;  // store the current beat and advance the crc
    logic rd_en;      // read the next payload byte from the buffer
    logic out_load;   // move buffer read data into the output register
  } slcpd_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_sync1;   // beat is the first sync byte
    logic is_sync2;   // beat is the second sync byte
    logic len_ok;     // beat is a usable length
    logic pkt_done;   // beat is the final byte of the packet
    logic crc_ok;     // residue including this beat is zero
    logic rd_last;    // byte in flight from the buffer is the last payload byte
    logic out_free;   // output register is empty or drains this cycle
  } slcpd_sts_t;

  // one byte of msb-first crc, non-reflected
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0]  crc,
                                                 input logic [BYTE_W-1:0] b,
                                                 input logic [CRC_W-1:0]  poly);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/slcpd_ram.sv =====
// generic single-write, single-read ram with registered read data
module slcpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/slcpd_dp.sv =====
// datapath: polynomial register, length and byte counters, crc, buffer and output register
module slcpd_dp #(
  parameter int unsigned MAX_PACKET_BYTES = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_wen_i,
  input  logic [15:0]                cfg_wdata_i,
  input  logic [7:0]                 rx_byte_i,
  input  slcpd_pkg::slcpd_cmd_t      cmd_i,
  output slcpd_pkg::slcpd_sts_t      sts_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [7:0]                 out_byte_o,
  output logic [4:0]                 out_len_o,
  output logic                       out_last_o
);
  import slcpd_pkg::*;

  localparam int unsigned AW = (MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1;

  logic [CRC_W-1:0]  poly_q, poly_d;
  logic [CNT_W-1:0]  len_q, len_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic [CRC_W-1:0]  crc_q, crc_d;
  logic [CRC_W-1:0]  crc_next;
  logic              rd_last_q, rd_last_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q;
  logic [PLEN_W-1:0] out_len_q;
  logic              out_last_q;
  logic [BYTE_W-1:0] ram_rdata;
  logic [CNT_W-1:0]  plen;

  assign crc_next = crc_byte(crc_q, rx_byte_i, poly_q);
  assign plen     = len_q - CNT_W'(2);

  // status toward the controller
  always_comb begin
    sts_o.is_sync1 = (rx_byte_i == SYNC_FIRST);
    sts_o.is_sync2 = (rx_byte_i == SYNC_SECOND);
    sts_o.len_ok   = (rx_byte_i >= MIN_LEN) && (rx_byte_i <= BYTE_W'(MAX_PACKET_BYTES));
    sts_o.pkt_done = ((cnt_q + CNT_W'(1)) == len_q);
    sts_o.crc_ok   = (crc_next == '0);
    sts_o.rd_last  = rd_last_q;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  // counters, crc and configuration
  always_comb begin
    poly_d    = poly_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    crc_d     = crc_q;
    rd_idx_d  = rd_idx_q;
    rd_last_d = rd_last_q;
    if (cfg_wen_i) begin
      poly_d = cfg_wdata_i;
    end
    if (cmd_i.len_load) begin
      len_d    = rx_byte_i[CNT_W-1:0];
      cnt_d    = '0;
      crc_d    = '0;
      rd_idx_d = '0;
    end
    if (cmd_i.byte_take) begin
      cnt_d = cnt_q + CNT_W'(1);
      crc_d = crc_next;
    end
    if (cmd_i.rd_en) begin
      rd_idx_d  = rd_idx_q + CNT_W'(1);
      rd_last_d = (rd_idx_q == plen - CNT_W'(1));
    end
  end

  // output register: loaded from the buffer, cleared when the beat is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q      <= CRC_POLY_RST;
      len_q       <= '0;
      cnt_q       <= '0;
      crc_q       <= '0;
      rd_idx_q    <= '0;
      rd_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      poly_q      <= poly_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      crc_q       <= crc_d;
      rd_idx_q    <= rd_idx_d;
      rd_last_q   <= rd_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_byte_q <= ram_rdata;
      out_len_q  <= plen[PLEN_W-1:0];
      out_last_q <= rd_last_q;
    end
  end

  // packet buffer
  slcpd_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MAX_PACKET_BYTES)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (cmd_i.byte_take),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(rx_byte_i),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_idx_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_len_o   = out_len_q;
  assign out_last_o  = out_last_q;

  // a held beat is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !out_valid_q)
    else $error("output register loaded while holding a beat");

  // bytes are only stored below the announced length
  a_store_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.byte_take |-> (cnt_q < len_q) && (len_q <= CNT_W'(MAX_PACKET_BYTES)))
    else $error("byte stored beyond packet length");

endmodule

// ===== hw/rtl/slcpd_ctrl.sv =====
// controller: sync hunt, length, collection and payload drain sequencing
module slcpd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  slcpd_pkg::slcpd_sts_t sts_i,
  output slcpd_pkg::slcpd_cmd_t cmd_o
);
  import slcpd_pkg::*;

  typedef enum logic [5:0] {
    ST_HUNT     = 6'b000001,
    ST_NEED_AA  = 6'b000010,
    ST_NEED_LEN = 6'b000100,
    ST_DATA     = 6'b001000,
    ST_DRAIN_RD = 6'b010000,
    ST_DRAIN_LD = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   acc;

  // input is open in every state except the drain
  assign in_ready_o = (state_q == ST_HUNT) || (state_q == ST_NEED_AA) ||
                      (state_q == ST_NEED_LEN) || (state_q == ST_DATA);
  assign acc = in_valid_i && in_ready_o;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_HUNT: begin
        if (acc && sts_i.is_sync1) begin
          state_d = ST_NEED_AA;
        end
      end
      ST_NEED_AA: begin
        if (acc) begin
          if (sts_i.is_sync2) begin
            state_d = ST_NEED_LEN;
          end else if (!sts_i.is_sync1) begin
            state_d = ST_HUNT;
          end
        end
      end
      ST_NEED_LEN: begin
        if (acc && sts_i.len_ok) begin
          cmd_o.len_load = 1'b1;
          state_d        = ST_DATA;
        end
      end
      ST_DATA: begin
        if (acc) begin
          cmd_o.byte_take = 1'b1;
          if (sts_i.pkt_done) begin
            state_d = sts_i.crc_ok ? ST_DRAIN_RD : ST_HUNT;
          end
        end
      end
      ST_DRAIN_RD: begin
        if (sts_i.out_free) begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_DRAIN_LD;
        end
      end
      ST_DRAIN_LD: begin
        cmd_o.out_load = 1'b1;
        state_d        = sts_i.rd_last ? ST_HUNT : ST_DRAIN_RD;
      end
      default: begin
        state_d = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  // every buffer read lands in the output register in the next cycle
  a_rd_then_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |=> cmd_o.out_load)
    else $error("buffer read without output load");

  // input stays held off while a packet drains
  a_no_take_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.rd_en || cmd_o.out_load) |-> !(cmd_o.byte_take || cmd_o.len_load))
    else $error("input taken during drain");

endmodule

// ===== hw/rtl/sync_length_crc_packet_deframer_top.sv =====
// Top level of the sync/length/CRC-16 packet deframer.
// Throughput: one received byte per cycle while hunting, reading the length and collecting.
// After the last packet byte with a zero residue, payload beats leave one at a time, each
// by a buffer read and then an output register load, a read waiting for a free register,
// and input is held off until the last beat sits in the output register.
// Reset: controller to hunting, counters and crc cleared, polynomial 0x1021; buffer undefined.
module sync_length_crc_packet_deframer_top #(
  parameter int unsigned MAX_PACKET_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: crc polynomial
  input  logic        cfg_wen_i,
  input  logic [15:0] cfg_wdata_i,
  // received bytes
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  // payload beats
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] payload_byte, [12:8] payload_length, zero above
  output logic        m_axis_tlast_o    // payload_last
);
  import slcpd_pkg::*;

  slcpd_cmd_t        cmd;
  slcpd_sts_t        sts;
  logic [BYTE_W-1:0] out_byte;
  logic [PLEN_W-1:0] out_len;

  // sequencing
  slcpd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // datapath and buffer
  slcpd_dp #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_wen_i  (cfg_wen_i),
    .cfg_wdata_i(cfg_wdata_i),
    .rx_byte_i  (s_axis_tdata_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_ready_i(m_axis_tready_i),
    .out_valid_o(m_axis_tvalid_o),
    .out_byte_o (out_byte),
    .out_len_o  (out_len),
    .out_last_o (m_axis_tlast_o)
  );

  // pack the output beat
  assign m_axis_tdata_o = {(OUT_TDATA_W - PLEN_W - BYTE_W)'(0), out_len, out_byte};

endmodule

// ===== tb/sv/slcpd_payload_checker.sv =====
// payload checker for the sync/length/crc packet deframer: predicts and compares output beats
`timescale 1ns / 1ps

module slcpd_payload_checker #(
  parameter int unsigned FRAME_MAX = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wen_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        rx_valid_i,
  input  logic        rx_ready_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        pl_valid_i,
  input  logic        pl_ready_i,
  input  logic [15:0] pl_data_i,
  input  logic        pl_last_i,
  output int          fail_count_o,
  output int          pending_o
);
  import slcpd_pkg::*;

  localparam int unsigned BUF_AW = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_NEED_AA,
    PH_NEED_LEN,
    PH_DATA
  } rx_phase_e;

  typedef struct packed {
    logic [7:0] byte_val;
    logic [4:0] plen;
    logic       last_flag;
  } payload_beat_t;

  rx_phase_e     phase_q;
  logic [5:0]    frame_len;
  logic [5:0]    byte_cnt;
  logic [15:0]   crc_q;
  logic [15:0]   poly_q;
  logic [7:0]    frame_buf [FRAME_MAX];
  payload_beat_t payload_q [$];

  // advance the deframer state by one received byte, queue any payload it releases
  task automatic deframe_byte(input logic [7:0] b);
    payload_beat_t beat;
    int            plen;
    case (phase_q)
      PH_HUNT: begin
        if (b == SYNC_FIRST) phase_q = PH_NEED_AA;
      end
      PH_NEED_AA: begin
        if (b == SYNC_SECOND) phase_q = PH_NEED_LEN;
        else if (b != SYNC_FIRST) phase_q = PH_HUNT;
      end
      PH_NEED_LEN: begin
        // out-of-range lengths are skipped, the next byte is tried
        if (b >= MIN_LEN && b <= FRAME_MAX) begin
          frame_len = b[5:0];
          byte_cnt  = '0;
          crc_q     = '0;
          phase_q   = PH_DATA;
        end
      end
      default: begin
        if (frame_len < MIN_LEN || frame_len > FRAME_MAX || byte_cnt >= frame_len) begin
          phase_q = PH_HUNT;
        end else begin
          frame_buf[byte_cnt[BUF_AW-1:0]] = b;
          // bit-serial form of the msb-first crc
          for (int i = 7; i >= 0; i--) begin
            crc_q = {crc_q[14:0], 1'b0} ^ ((crc_q[15] ^ b[i]) ? poly_q : 16'h0000);
          end
          byte_cnt = byte_cnt + 6'd1;
          if (byte_cnt == frame_len) begin
            // zero residue releases the payload, anything else is dropped
            if (crc_q == 16'h0000) begin
              plen = int'(frame_len) - 2;
              for (int k = 0; k < plen; k++) begin
                beat.byte_val  = frame_buf[k[BUF_AW-1:0]];
                beat.plen      = plen[4:0];
                beat.last_flag = (k == plen - 1);
                payload_q.push_back(beat);
              end
            end
            phase_q = PH_HUNT;
          end
        end
      end
    endcase
  endtask

  // compare one output beat with the oldest queued payload byte
  task automatic check_beat();
    payload_beat_t exp_beat;
    if (payload_q.size() == 0) begin
      $error("unexpected payload beat: tdata %h tlast %b", pl_data_i, pl_last_i);
      fail_count_o++;
    end else begin
      exp_beat = payload_q.pop_front();
      if (pl_data_i[7:0] !== exp_beat.byte_val) begin
        $error("payload_byte: expected %h, got %h", exp_beat.byte_val, pl_data_i[7:0]);
        fail_count_o++;
      end
      if (pl_data_i[12:8] !== exp_beat.plen) begin
        $error("payload_length: expected %0d, got %0d", exp_beat.plen, pl_data_i[12:8]);
        fail_count_o++;
      end
      if (pl_last_i !== exp_beat.last_flag) begin
        $error("payload_last: expected %b, got %b", exp_beat.last_flag, pl_last_i);
        fail_count_o++;
      end
      if (pl_data_i[15:13] !== 3'b000) begin
        $error("tdata padding: expected 0, got %b", pl_data_i[15:13]);
        fail_count_o++;
      end
    end
  endtask

  // all bookkeeping happens at the clock edge, on values from before the edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   = PH_HUNT;
      frame_len = '0;
      byte_cnt  = '0;
      crc_q     = '0;
      poly_q    = CRC_POLY_RST;
      payload_q.delete();
    end else begin
      if (rx_valid_i && rx_ready_i) deframe_byte(rx_byte_i);
      if (pl_valid_i && pl_ready_i) check_beat();
      if (cfg_wen_i) poly_q = cfg_wdata_i;
    end
    pending_o = payload_q.size();
  end

endmodule

// ===== tb/sv/tb_sync_length_crc_packet_deframer_top.sv =====
// testbench top for the sync/length/crc packet deframer: stimulus, backpressure and verdict
`timescale 1ns / 1ps

module tb_sync_length_crc_packet_deframer_top;
  import slcpd_pkg::*;

  localparam int unsigned FRAME_MAX_BYTES = 32;
  localparam int          SETTLE_CYCLES   = 12;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int          BYTES_PER_POLY  = 60;

  logic        clk_i;
  logic        rst_n         = 1'b0;
  logic        cfg_wen       = 1'b0;
  logic [15:0] cfg_wdata     = 16'h0000;
  logic        rx_tvalid     = 1'b0;
  logic        rx_tready;
  logic [7:0]  rx_tdata      = 8'h00;
  logic        pl_tvalid;
  logic        pl_tready     = 1'b0;
  logic [15:0] pl_tdata;
  logic        pl_tlast;

  int          fail_count;
  int          pending_cnt;
  int          hold_off_req  = 0;
  int          hold_off_done = 0;
  int          burst_left    = 0;
  int          frame_bytes;
  logic [15:0] cur_poly      = CRC_POLY_RST;
  logic [7:0]  frame_q [$];
  logic [15:0] poly_list [5];

  sync_length_crc_packet_deframer_top #(
    .MAX_PACKET_BYTES(FRAME_MAX_BYTES)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_wen_i      (cfg_wen),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(rx_tvalid),
    .s_axis_tready_o(rx_tready),
    .s_axis_tdata_i (rx_tdata),
    .m_axis_tvalid_o(pl_tvalid),
    .m_axis_tready_i(pl_tready),
    .m_axis_tdata_o (pl_tdata),
    .m_axis_tlast_o (pl_tlast)
  );

  slcpd_payload_checker #(
    .FRAME_MAX(FRAME_MAX_BYTES)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_wen_i   (cfg_wen),
    .cfg_wdata_i (cfg_wdata),
    .rx_valid_i  (rx_tvalid),
    .rx_ready_i  (rx_tready),
    .rx_byte_i   (rx_tdata),
    .pl_valid_i  (pl_tvalid),
    .pl_ready_i  (pl_tready),
    .pl_data_i   (pl_tdata),
    .pl_last_i   (pl_tlast),
    .fail_count_o(fail_count),
    .pending_o   (pending_cnt)
  );

  // 125 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // single reset pulse at the start
  initial begin
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("FAIL sync_length_crc_packet_deframer_top");
    $finish;
  end

  // receiver: random stall patterns, plus a long hold-off on request
  initial begin
    int mode;
    int pattern_left;
    int hold_left;
    mode         = 0;
    pattern_left = 0;
    hold_left    = 0;
    wait (rst_n);
    forever begin
      @(posedge clk_i);
      if (hold_off_req != hold_off_done) begin
        hold_off_done++;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pl_tready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          mode         = $urandom_range(0, 2);
          pattern_left = $urandom_range(20, 200);
        end
        pattern_left--;
        case (mode)
          0:       pl_tready <= 1'b1;
          1:       pl_tready <= 1'($urandom_range(0, 1));
          default: pl_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // offer one byte, with bursts and random gaps between them
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        rx_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    rx_tvalid <= 1'b1;
    rx_tdata  <= b;
    do @(posedge clk_i); while (!rx_tready);
  endtask

  task automatic send_queue();
    foreach (frame_q[i]) send_byte(frame_q[i]);
    frame_q.delete();
  endtask

  // append crc of the last len-2 queued bytes, optionally flip one bit of the packet
  function automatic void seal_frame(input int len, input bit corrupt);
    logic [15:0] c;
    int          base;
    int          idx;
    c    = 16'h0000;
    base = frame_q.size() - (len - 2);
    for (int k = base; k < frame_q.size(); k++) begin
      c = c ^ {frame_q[k], 8'h00};
      repeat (8) c = c[15] ? ({c[14:0], 1'b0} ^ cur_poly) : {c[14:0], 1'b0};
    end
    frame_q.push_back(c[15:8]);
    frame_q.push_back(c[7:0]);
    if (corrupt) begin
      idx          = frame_q.size() - 1 - $urandom_range(0, len - 1);
      frame_q[idx] = frame_q[idx] ^ (8'h01 << $urandom_range(0, 7));
    end
  endfunction

  // stop offering, wait for every expected beat, then let the pipeline empty
  task automatic settle();
    rx_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_cnt != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_poly(input logic [15:0] p);
    settle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk_i);
    cfg_wen   <= 1'b0;
    cur_poly  = p;
  endtask

  // stimulus
  initial begin
    int len;
    int pick;
    int noise_len;
    logic [7:0] bad_len;
    poly_list[0] = CRC_POLY_RST;
    poly_list[1] = 16'h0000;
    poly_list[2] = 16'hFFFF;
    poly_list[3] = 16'h8005;
    poly_list[4] = 16'($urandom_range(0, 16'hFFFF));
    wait (rst_n);
    @(posedge clk_i);

    // byte extremes and a sync byte followed by junk
    frame_q = {8'h00, 8'hFF, SYNC_FIRST, 8'h12};
    send_queue();
    // repeated first sync, lengths too short and too long, then a minimum packet
    frame_q = {SYNC_FIRST, SYNC_FIRST, SYNC_SECOND, 8'h03, 8'h21, 8'h00, 8'hFF,
               MIN_LEN, 8'h00, 8'hFF};
    seal_frame(4, 1'b0);
    send_queue();
    // packet with a broken checksum is dropped
    frame_q = {SYNC_FIRST, SYNC_SECOND, MIN_LEN, 8'hA5, 8'h5A};
    seal_frame(4, 1'b1);
    send_queue();

    // random traffic under several polynomials
    foreach (poly_list[p]) begin
      write_poly(poly_list[p]);
      frame_bytes = 0;
      // fill the block while the receiver holds off
      if (p == 1) begin
        hold_off_req++;
        for (int f = 0; f < 2; f++) begin
          frame_q = {SYNC_FIRST, SYNC_SECOND, 8'(FRAME_MAX_BYTES)};
          repeat (FRAME_MAX_BYTES - 2) frame_q.push_back(8'($urandom_range(0, 255)));
          seal_frame(FRAME_MAX_BYTES, 1'b0);
          frame_bytes += frame_q.size();
          send_queue();
        end
      end
      while (frame_bytes < BYTES_PER_POLY) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          // line noise
          noise_len = $urandom_range(1, 6);
          repeat (noise_len) frame_q.push_back(8'($urandom_range(0, 255)));
          send_queue();
        end else begin
          len = ($urandom_range(0, 7) == 0) ? FRAME_MAX_BYTES : $urandom_range(4, 14);
          frame_q.push_back(SYNC_FIRST);
          if ($urandom_range(0, 3) == 0) frame_q.push_back(SYNC_FIRST);
          frame_q.push_back(SYNC_SECOND);
          if ($urandom_range(0, 5) == 0) begin
            bad_len = 8'($urandom_range(0, 1) ? $urandom_range(0, MIN_LEN - 1)
                                              : $urandom_range(FRAME_MAX_BYTES + 1, 255));
            frame_q.push_back(bad_len);
          end
          frame_q.push_back(8'(len));
          repeat (len - 2) frame_q.push_back(8'($urandom_range(0, 255)));
          seal_frame(len, pick == 1);
          frame_bytes += frame_q.size();
          send_queue();
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("PASS sync_length_crc_packet_deframer_top");
    end else begin
      $display("FAIL sync_length_crc_packet_deframer_top");
    end
    $finish;
  end

endmodule
